### hdl/omw_pkg.sv
// Shared package for the omni wheel odometry block.
// Fixed-point constants, micro-op codes, command struct and the CORDIC angle table.
// No dependencies.
package omw_pkg;

    localparam int DEF_POSITION_WIDTH = 32;
    localparam int DEF_ENCODER_WIDTH  = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 32;
    localparam int HEAD_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_DISTANCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CENTER_DIST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE    = 2'd2;

    localparam logic [CFG_W-1:0] RST_TICK_DISTANCE   = 16'd5568;
    localparam logic [CFG_W-1:0] RST_INV_CENTER_DIST = 16'd5350;
    localparam logic [CFG_W-1:0] RST_OUTPUT_SCALE    = 16'd17899;

    localparam int PI_Q13        = 25736;
    localparam int TWO_PI_Q13    = 51472;
    localparam int HALF_PI_Q13   = 12868;
    localparam int INV_SQRT3_Q16 = 37838;
    localparam int ONE_THIRD_Q16 = 21845;
    localparam int CORDIC_K_Q28  = 163008219;
    localparam int CORDIC_STEPS  = 16;

    localparam int ITER_W = 6;
    localparam logic [ITER_W-1:0] CORDIC_LAST = ITER_W'(CORDIC_STEPS - 1);

    typedef enum logic [5:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLEAR,
        OP_S0,
        OP_S1,
        OP_S2,
        OP_S3,
        OP_DF,
        OP_MF,
        OP_DN,
        OP_MN,
        OP_DM,
        OP_MM,
        OP_ST,
        OP_MT,
        OP_TURN,
        OP_WSTEP,
        OP_WHALF,
        OP_CINIT,
        OP_CSTEP,
        OP_CFIN,
        OP_HLOAD,
        OP_WHEAD,
        OP_R1,
        OP_R2,
        OP_R3,
        OP_R4,
        OP_R5,
        OP_R6,
        OP_R7,
        OP_O1,
        OP_O2,
        OP_O3,
        OP_PUB
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ITER_W-1:0] iter;
    } cmd_t;

    function automatic int atan_q16(input logic [3:0] i);
        int r;
        case (i)
            4'd0:    r = 51472;
            4'd1:    r = 30386;
            4'd2:    r = 16055;
            4'd3:    r = 8150;
            4'd4:    r = 4091;
            4'd5:    r = 2047;
            4'd6:    r = 1024;
            4'd7:    r = 512;
            4'd8:    r = 256;
            4'd9:    r = 128;
            4'd10:   r = 64;
            4'd11:   r = 32;
            4'd12:   r = 16;
            4'd13:   r = 8;
            4'd14:   r = 4;
            default: r = 2;
        endcase
        return r;
    endfunction

endpackage

### hdl/omni_wheel_odometry.sv
// Top level of the three-wheel omni odometry block.
// Joins the sequencer omw_ctrl and the datapath omw_dp; depends on omw_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one word carries opcode and three raw
//   encoder counts. opcode 0 integrates the sample, opcode 1 clears pose,
//   heading and stored counts and answers with an all-zero result.
//   Output channel (out_valid/out_ready): one word per input word, x_cm and
//   y_cm in signed Q16.16 cm (pose times output_scale), heading in Q3.13 rad.
//   Config port: cfg_we with cfg_index 0..2 writes tick_distance,
//   inv_center_distance, output_scale; index 3 is ignored. Write only while idle.
// Sequence:
//   A sample word runs one micro-op per cycle on a single shared multiplier,
//   plus two passes of the shift-subtract angle reducer and a 16-step CORDIC;
//   the final publish step waits while the output slot is still held.
//   A clear word goes straight to the publish step. One word is in flight at
//   a time; in_ready is high again once the result sits in the output register.
// Reset: pose, heading and stored counts go to zero, config registers to
//   their default values, no output word is pending.
// Stall: a held result waits in the output register; the next word can be
//   accepted and processed, and its result waits until the slot is taken.
module omni_wheel_odometry
    import omw_pkg::*;
#(
    parameter int POSITION_WIDTH = DEF_POSITION_WIDTH,
    parameter int ENCODER_WIDTH  = DEF_ENCODER_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     opcode,
    input  logic [ENCODER_WIDTH-1:0] count_a,
    input  logic [ENCODER_WIDTH-1:0] count_b,
    input  logic [ENCODER_WIDTH-1:0] count_c,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  x_cm,
    output logic signed [OUT_W-1:0]  y_cm,
    output logic signed [HEAD_W-1:0] heading
);

    cmd_t cmd;

    // sequencer: handshakes, micro-op order, loop counters
    omw_ctrl #(
        .ENCODER_WIDTH  (ENCODER_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath: state, shared multiplier, wrap reducer, CORDIC, output regs
    omw_dp #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .ENCODER_WIDTH  (ENCODER_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .count_a   (count_a),
        .count_b   (count_b),
        .count_c   (count_c),
        .x_cm      (x_cm),
        .y_cm      (y_cm),
        .heading   (heading)
    );

endmodule

### hdl/omw_ctrl.sv
// Sequencer for the odometry datapath: walks the micro-op list per word,
// runs the wrap and CORDIC loops, owns the handshakes. Depends on omw_pkg.
module omw_ctrl
    import omw_pkg::*;
#(
    parameter int ENCODER_WIDTH  = DEF_ENCODER_WIDTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic opcode,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    // wrap reduction runs from the top shift down to zero
    localparam int UW = ENCODER_WIDTH + 21;
    localparam logic [ITER_W-1:0] WRAP_LAST = ITER_W'(UW - 15);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SEQ  = 4'b0010,
        S_LOOP = 4'b0100,
        S_PUB  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              wrap2_reg, wrap2_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        wrap2_next     = wrap2_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NOP;
        cmd.iter       = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode)
                    begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_PUB;
                    end
                    else
                    begin
                        cmd.op     = OP_LOAD;
                        op_next    = OP_S0;
                        state_next = S_SEQ;
                    end
                end
            end
            S_SEQ:
            begin
                cmd.op = op_reg;
                if (op_reg == OP_TURN || op_reg == OP_HLOAD)
                begin
                    op_next    = OP_WSTEP;
                    cnt_next   = WRAP_LAST;
                    wrap2_next = (op_reg == OP_HLOAD);
                    state_next = S_LOOP;
                end
                else if (op_reg == OP_CINIT)
                begin
                    op_next    = OP_CSTEP;
                    cnt_next   = '0;
                    state_next = S_LOOP;
                end
                else if (op_reg == OP_O3)
                begin
                    state_next = S_PUB;
                end
                else
                begin
                    op_next = op_t'(op_reg + 6'd1);
                end
            end
            S_LOOP:
            begin
                cmd.op = op_reg;
                if (op_reg == OP_WSTEP)
                begin
                    if (cnt_reg == '0)
                    begin
                        op_next    = wrap2_reg ? OP_WHEAD : OP_WHALF;
                        state_next = S_SEQ;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                else
                begin
                    if (cnt_reg == CORDIC_LAST)
                    begin
                        op_next    = OP_CFIN;
                        state_next = S_SEQ;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_PUB:
            begin
                if (slot_free)
                begin
                    cmd.op         = OP_PUB;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NOP;
            cnt_reg       <= '0;
            wrap2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            wrap2_reg     <= wrap2_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/omw_dp.sv
// Odometry datapath: config registers, pose state, one shared multiplier,
// angle wrap reducer and CORDIC rotator. Driven by omw_ctrl; depends on omw_pkg.
module omw_dp
    import omw_pkg::*;
#(
    parameter int POSITION_WIDTH = DEF_POSITION_WIDTH,
    parameter int ENCODER_WIDTH  = DEF_ENCODER_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic [ENCODER_WIDTH-1:0] count_a,
    input  logic [ENCODER_WIDTH-1:0] count_b,
    input  logic [ENCODER_WIDTH-1:0] count_c,
    output logic signed [OUT_W-1:0]  x_cm,
    output logic signed [OUT_W-1:0]  y_cm,
    output logic signed [HEAD_W-1:0] heading
);

    localparam int EW = ENCODER_WIDTH;
    localparam int PW_POS = POSITION_WIDTH;
    localparam int DW = EW + 1;
    localparam int SW = DW + 17;
    localparam int TW = SW + 2;
    localparam int UW = TW + 1;
    localparam int AW = (TW > PW_POS) ? TW : PW_POS;
    localparam int BW = 18;
    localparam int PW = AW + BW;
    localparam int CW = 32;
    localparam int ZW = 20;
    localparam int AGW = 17;

    typedef enum logic [1:0] {
        WM_IN = 2'd0,
        WM_HI = 2'd1,
        WM_LO = 2'd2
    } wmode_t;

    // config and architectural state
    logic [CFG_W-1:0]          tick_reg, inv_reg, oscale_reg;
    logic [EW-1:0]             prev_a_reg, prev_b_reg, prev_c_reg;
    logic signed [PW_POS-1:0]  pos_x_reg, pos_y_reg;
    logic signed [HEAD_W-1:0]  head_reg;

    // work registers
    logic signed [DW-1:0]  d0_reg, d1_reg, d2_reg;
    logic signed [SW-1:0]  s0_reg, s1_reg, s2_reg;
    logic signed [TW-1:0]  t_reg, fwd_reg, nrm_reg, dth_reg;
    logic signed [PW-1:0]  p_reg, acc_reg;
    logic [UW-1:0]         w_r_reg;
    logic signed [AGW-1:0] w_val_reg;
    wmode_t                w_mode_reg;
    logic signed [AGW-1:0] half_reg;
    logic signed [CW-1:0]  cx_reg, cy_reg;
    logic signed [ZW-1:0]  cz_reg;
    logic                  flip_reg;
    logic signed [BW-1:0]  cc_reg, sn_reg;
    logic signed [OUT_W-1:0] xs_reg, ys_reg;

    // shared multiplier operands
    logic signed [AW-1:0] ma;
    logic signed [BW-1:0] mb;

    logic signed [PW-1:0] p_r16, p_r19, p_r20, acc_r14;
    logic signed [UW:0]   wl_val;
    logic [UW:0]          w_cmp;
    logic signed [AGW-1:0] w_res;
    logic signed [AGW-1:0] fold_a;
    logic                  fold_flip;
    logic signed [CW-1:0]  cx_r14, cy_r14;
    logic [3:0]            ci;

    assign p_r16   = (p_reg + $signed(PW'(1) << 15)) >>> 16;
    assign p_r19   = (p_reg + $signed(PW'(1) << 18)) >>> 19;
    assign p_r20   = (p_reg + $signed(PW'(1) << 19)) >>> 20;
    assign acc_r14 = (acc_reg + $signed(PW'(1) << 13)) >>> 14;
    assign cx_r14  = (cx_reg + $signed(CW'(8192))) >>> 14;
    assign cy_r14  = (cy_reg + $signed(CW'(8192))) >>> 14;
    assign ci      = cmd.iter[3:0];
    assign w_cmp   = (UW + 1)'(TWO_PI_Q13) << cmd.iter;

    // value handed to the wrap reducer
    assign wl_val = (cmd.op == OP_TURN) ? (UW + 1)'(TW'(p_r20))
                                        : (UW + 1)'(head_reg) + (UW + 1)'(dth_reg);

    // wrapped angle from reducer state
    always_comb
    begin
        case (w_mode_reg)
            WM_HI:   w_res = (w_r_reg == '0) ? AGW'(PI_Q13)
                                             : $signed(AGW'(w_r_reg)) - AGW'(PI_Q13);
            WM_LO:   w_res = (w_r_reg == '0) ? -AGW'(PI_Q13)
                                             : AGW'(PI_Q13) - $signed(AGW'(w_r_reg));
            default: w_res = w_val_reg;
        endcase
    end

    // fold into +-pi/2 before CORDIC
    always_comb
    begin
        fold_a    = half_reg;
        fold_flip = 1'b0;
        if (half_reg > AGW'(HALF_PI_Q13))
        begin
            fold_a    = half_reg - AGW'(PI_Q13);
            fold_flip = 1'b1;
        end
        else if (half_reg < -AGW'(HALF_PI_Q13))
        begin
            fold_a    = half_reg + AGW'(PI_Q13);
            fold_flip = 1'b1;
        end
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op) inside
            OP_S0:
            begin
                ma = AW'(d0_reg);
                mb = $signed({2'b00, tick_reg});
            end
            OP_S1:
            begin
                ma = AW'(d1_reg);
                mb = $signed({2'b00, tick_reg});
            end
            OP_S2:
            begin
                ma = AW'(d2_reg);
                mb = $signed({2'b00, tick_reg});
            end
            OP_MF:
            begin
                ma = AW'(t_reg);
                mb = BW'(INV_SQRT3_Q16);
            end
            OP_MN, OP_MM:
            begin
                ma = AW'(t_reg);
                mb = BW'(ONE_THIRD_Q16);
            end
            OP_MT:
            begin
                ma = AW'(t_reg);
                mb = $signed({2'b00, inv_reg});
            end
            OP_R1:
            begin
                ma = AW'(fwd_reg);
                mb = sn_reg;
            end
            OP_R2:
            begin
                ma = AW'(nrm_reg);
                mb = cc_reg;
            end
            OP_R4:
            begin
                ma = AW'(nrm_reg);
                mb = sn_reg;
            end
            OP_R5:
            begin
                ma = AW'(fwd_reg);
                mb = cc_reg;
            end
            OP_O1:
            begin
                ma = AW'(pos_x_reg);
                mb = $signed({2'b00, oscale_reg});
            end
            OP_O2:
            begin
                ma = AW'(pos_y_reg);
                mb = $signed({2'b00, oscale_reg});
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // config and architectural state; reset loads config defaults, clears the rest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= RST_TICK_DISTANCE;
            inv_reg    <= RST_INV_CENTER_DIST;
            oscale_reg <= RST_OUTPUT_SCALE;
            prev_a_reg <= '0;
            prev_b_reg <= '0;
            prev_c_reg <= '0;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            head_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TICK_DISTANCE:   tick_reg   <= cfg_data;
                    CFG_INV_CENTER_DIST: inv_reg    <= cfg_data;
                    CFG_OUTPUT_SCALE:    oscale_reg <= cfg_data;
                    default:             ;
                endcase
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    prev_a_reg <= count_a;
                    prev_b_reg <= count_b;
                    prev_c_reg <= count_c;
                end
                OP_CLEAR:
                begin
                    prev_a_reg <= '0;
                    prev_b_reg <= '0;
                    prev_c_reg <= '0;
                    pos_x_reg  <= '0;
                    pos_y_reg  <= '0;
                    head_reg   <= '0;
                end
                OP_WHEAD: head_reg  <= HEAD_W'(w_res);
                OP_R4:    pos_x_reg <= pos_x_reg + PW_POS'(acc_r14);
                OP_R7:    pos_y_reg <= pos_y_reg + PW_POS'(acc_r14);
                default:  ;
            endcase
        end
    end

    // work registers, product register and output registers
    always_ff @(posedge clk)
    begin
        p_reg <= ma * mb;
        case (cmd.op) inside
            OP_LOAD:
            begin
                d0_reg <= DW'($signed(count_a)) - DW'($signed(prev_a_reg));
                d1_reg <= DW'($signed(count_b)) - DW'($signed(prev_b_reg));
                d2_reg <= DW'($signed(count_c)) - DW'($signed(prev_c_reg));
            end
            OP_CLEAR:
            begin
                xs_reg <= '0;
                ys_reg <= '0;
            end
            OP_S1: s0_reg <= SW'(p_reg);
            OP_S2: s1_reg <= SW'(p_reg);
            OP_S3: s2_reg <= SW'(p_reg);
            OP_DF: t_reg  <= TW'(s2_reg) - TW'(s0_reg);
            OP_DN:
            begin
                fwd_reg <= TW'(p_r16);
                t_reg   <= TW'(s0_reg) - (TW'(s1_reg) <<< 1) + TW'(s2_reg);
            end
            OP_DM:
            begin
                nrm_reg <= TW'(p_r16);
                t_reg   <= TW'(s0_reg) + TW'(s1_reg) + TW'(s2_reg);
            end
            OP_ST: t_reg <= TW'(p_r16);
            OP_TURN, OP_HLOAD:
            begin
                if (cmd.op == OP_TURN)
                begin
                    dth_reg <= TW'(p_r19);
                end
                w_val_reg <= AGW'(wl_val);
                w_r_reg   <= '0;
                if (wl_val > (UW + 1)'(PI_Q13))
                begin
                    w_mode_reg <= WM_HI;
                    w_r_reg    <= UW'(wl_val - (UW + 1)'(PI_Q13));
                end
                else if (wl_val < -(UW + 1)'(PI_Q13))
                begin
                    w_mode_reg <= WM_LO;
                    w_r_reg    <= UW'(-(UW + 1)'(PI_Q13) - wl_val);
                end
                else
                begin
                    w_mode_reg <= WM_IN;
                end
            end
            OP_WSTEP:
            begin
                if ({1'b0, w_r_reg} >= w_cmp)
                begin
                    w_r_reg <= UW'({1'b0, w_r_reg} - w_cmp);
                end
            end
            OP_WHALF: half_reg <= w_res;
            OP_CINIT:
            begin
                cx_reg   <= CW'(CORDIC_K_Q28);
                cy_reg   <= '0;
                cz_reg   <= ZW'(fold_a) <<< 3;
                flip_reg <= fold_flip;
            end
            OP_CSTEP:
            begin
                if (cz_reg >= 0)
                begin
                    cx_reg <= cx_reg - (cy_reg >>> ci);
                    cy_reg <= cy_reg + (cx_reg >>> ci);
                    cz_reg <= cz_reg - ZW'(atan_q16(ci));
                end
                else
                begin
                    cx_reg <= cx_reg + (cy_reg >>> ci);
                    cy_reg <= cy_reg - (cx_reg >>> ci);
                    cz_reg <= cz_reg + ZW'(atan_q16(ci));
                end
            end
            OP_CFIN:
            begin
                cc_reg <= flip_reg ? -BW'(cx_r14) : BW'(cx_r14);
                sn_reg <= flip_reg ? -BW'(cy_r14) : BW'(cy_r14);
            end
            OP_R2: acc_reg <= p_reg;
            OP_R3: acc_reg <= acc_reg + p_reg;
            OP_R5: acc_reg <= p_reg;
            OP_R6: acc_reg <= acc_reg - p_reg;
            OP_O2: xs_reg  <= p_r16[OUT_W-1:0];
            OP_O3: ys_reg  <= p_r16[OUT_W-1:0];
            OP_PUB:
            begin
                x_cm    <= xs_reg;
                y_cm    <= ys_reg;
                heading <= head_reg;
            end
            default: ;
        endcase
    end

endmodule
